### rtl/core/hbcd_pkg.sv
// Shared types, constants and helper functions for the chunked body decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hbcd_pkg;

	localparam int SIZE_BITS = 32;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Encoding phrase searched in the header, first character in the top byte
	localparam int PHRASE_LEN = 26;
	localparam int PHRASE_BITS = 8 * PHRASE_LEN;
	localparam logic [PHRASE_BITS-1:0] PHRASE = "Transfer-Encoding: chunked";
	localparam logic [4:0] PHRASE_LAST = 5'(PHRASE_LEN - 1);

	// Header bytes needed ahead of the terminator's final LF for a non-empty header
	localparam logic [2:0] TAIL_MIN = 3'd4;

	// Bytes skipped after each chunk's data
	localparam logic [1:0] SKIP_LEN = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_end;
	} out_item_t;

	typedef struct packed {
		logic ended;
		logic hdr_short;
		logic chunked;
	} hdr_status_t;

	typedef struct packed {
		logic                 line_end;
		logic                 stop;
		logic [SIZE_BITS-1:0] size;
	} size_status_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_t;

	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_PLAIN  = 6'b000010,
		PH_SIZE   = 6'b000100,
		PH_DATA   = 6'b001000,
		PH_SKIP   = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	function automatic logic [7:0] phrase_char(input logic [4:0] idx);
		logic [PHRASE_BITS-1:0] sh;
		sh = PHRASE << {idx, 3'b000};
		return sh[PHRASE_BITS-1 -: 8];
	endfunction

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.is_hex = 1'b1;
		h.value  = 4'd0;
		if (c >= "0" && c <= "9") begin
			h.value = 4'(c - 8'h30);
		end else if (c >= "a" && c <= "f") begin
			h.value = 4'(c - 8'h57);
		end else if (c >= "A" && c <= "F") begin
			h.value = 4'(c - 8'h37);
		end else begin
			h.is_hex = 1'b0;
		end
		return h;
	endfunction

endpackage

### rtl/core/hbcd_hdr_scan.sv
// Header scanner: end-of-header detection and encoding phrase search.
// Depends on hbcd_pkg.
`timescale 1ns / 1ps

module hbcd_hdr_scan import hbcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        clear,
	input  logic [7:0]  data_in,
	output hdr_status_t status
);

	logic [1:0] crlf_q, crlf_d;
	logic [4:0] match_q, match_d;
	logic       chunked_q, chunked_d;
	logic [2:0] tail_q, tail_d;
	logic       ended;

	always_comb begin
		ended = 1'b0;
		case (crlf_q)
			2'd0: crlf_d = (data_in == CHAR_CR) ? 2'd1 : 2'd0;
			2'd1: crlf_d = (data_in == CHAR_LF) ? 2'd2 :
				(data_in == CHAR_CR) ? 2'd1 : 2'd0;
			2'd2: crlf_d = (data_in == CHAR_CR) ? 2'd3 : 2'd0;
			default: begin
				ended  = (data_in == CHAR_LF);
				crlf_d = (data_in == CHAR_CR) ? 2'd1 : 2'd0;
			end
		endcase
		if (ended) begin
			crlf_d = 2'd0;
		end

		// plain restart on mismatch, no partial-prefix fallback
		match_d   = match_q;
		chunked_d = chunked_q;
		if (!chunked_q) begin
			if (match_q <= PHRASE_LAST && data_in == phrase_char(match_q)) begin
				match_d = match_q + 5'd1;
			end else begin
				match_d = (data_in == phrase_char(5'd0)) ? 5'd1 : 5'd0;
			end
			if (match_d > PHRASE_LAST) begin
				chunked_d = 1'b1;
				match_d   = 5'd0;
			end
		end

		tail_d = (tail_q < TAIL_MIN) ? tail_q + 3'd1 : tail_q;
	end

	assign status.ended     = step & ended;
	assign status.hdr_short = (tail_q < TAIL_MIN);
	assign status.chunked   = chunked_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crlf_q    <= 2'd0;
			match_q   <= 5'd0;
			chunked_q <= 1'b0;
			tail_q    <= 3'd0;
		end else if (clear) begin
			crlf_q    <= 2'd0;
			match_q   <= 5'd0;
			chunked_q <= 1'b0;
			tail_q    <= 3'd0;
		end else if (step) begin
			crlf_q    <= crlf_d;
			match_q   <= match_d;
			chunked_q <= chunked_d;
			tail_q    <= tail_d;
		end
	end

endmodule

### rtl/core/hbcd_size_line.sv
// Chunk-size line parser: hex accumulation with saturation, line end detection.
// Depends on hbcd_pkg.
`timescale 1ns / 1ps

module hbcd_size_line import hbcd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic         clear,
	input  logic [7:0]   data_in,
	output size_status_t status
);

	logic [SIZE_BITS-1:0] accum_q, accum_d;
	logic                 digits_done_q, digits_done_d;
	logic                 nonzero_q, nonzero_d;
	logic                 prev_cr_q;
	logic                 line_end;
	hex_t                 hex;

	assign hex      = hex_decode(data_in);
	assign line_end = prev_cr_q && (data_in == CHAR_LF);

	always_comb begin
		accum_d       = accum_q;
		digits_done_d = digits_done_q;
		nonzero_d     = nonzero_q | prev_cr_q | (data_in != CHAR_CR);
		if (!digits_done_q) begin
			if (!hex.is_hex) begin
				digits_done_d = 1'b1;
			end else if (accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
				accum_d = '1;
			end else begin
				accum_d = {accum_q[SIZE_BITS-5:0], hex.value};
			end
		end
	end

	assign status.line_end = step & line_end;
	assign status.stop     = !nonzero_q || (accum_q == '0);
	assign status.size     = accum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q       <= '0;
			digits_done_q <= 1'b0;
			nonzero_q     <= 1'b0;
			prev_cr_q     <= 1'b0;
		end else if (clear || (step && line_end)) begin
			accum_q       <= '0;
			digits_done_q <= 1'b0;
			nonzero_q     <= 1'b0;
			prev_cr_q     <= 1'b0;
		end else if (step) begin
			accum_q       <= accum_d;
			digits_done_q <= digits_done_d;
			nonzero_q     <= nonzero_d;
			prev_cr_q     <= (data_in == CHAR_CR);
		end
	end

endmodule

### rtl/core/http_body_chunked_decoder_unit.sv
// Top level of the HTTP body extractor with chunked transfer decoding.
// Depends on hbcd_pkg, hbcd_hdr_scan and hbcd_size_line.
`timescale 1ns / 1ps

// Usage
//   Input channel  byte_valid / byte_stall / byte_data: one response byte per
//   transaction, with in_last set on the final byte of a response.
//   Output channel body_valid / body_stall / body_data: one transaction per
//   forwarded body byte (out_valid = 1), plus one for the final input byte
//   (out_end = 1, out_valid = 1 only if that byte is itself body).
//   Header bytes, size lines, chunk trailers and bytes after the last chunk
//   produce no transaction.
// Throughput: one byte per cycle while body_stall does not hold a result. Each
//   byte's whole step is a few compares, one 32-bit decrement and a 4-bit hex
//   shift-in between the input register and the result register; the
//   phase/counter feedback closes within that step.
// Path: a byte taken is held in the input register and stepped from there;
//   its result is registered in the output register that drives body_valid.
// Stall: a stalled result sits in the output register and holds the input
//   register with it, so byte_stall follows body_stall whenever both hold a
//   transaction, even for a byte that would give no result.
// Reset: arst_n clears all state to header search; the final byte of each
//   response does the same, so responses can follow back to back.

module http_body_chunked_decoder_unit import hbcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_data,
	output logic      body_valid,
	input  logic      body_stall,
	output out_item_t body_data
);

	// input register
	in_item_t  item_s1;
	logic      vld_s1;
	logic      adv_s1;
	logic      byte_fire;

	// output register
	out_item_t res_s2;
	logic      vld_s2;

	// decoder state
	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] remain_q, remain_d;
	logic [1:0]           skip_q, skip_d;

	logic         emit;
	logic         last;
	logic         has_res;
	hdr_status_t  hdr;
	size_status_t sz;

	assign last      = item_s1.in_last;
	assign byte_fire = byte_valid && !byte_stall;

	// s1 moves on unless the output register holds a stalled result
	assign adv_s1     = vld_s1 && (!vld_s2 || !body_stall);
	assign byte_stall = vld_s1 && !adv_s1;

	hbcd_hdr_scan u_hdr (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1 && (phase_q == PH_HEADER)),
		.clear   (adv_s1 && last),
		.data_in (item_s1.in_byte),
		.status  (hdr)
	);

	hbcd_size_line u_size (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1 && (phase_q == PH_SIZE)),
		.clear   (adv_s1 && last),
		.data_in (item_s1.in_byte),
		.status  (sz)
	);

	// Per-byte phase step
	always_comb begin
		phase_d  = phase_q;
		remain_d = remain_q;
		skip_d   = skip_q;
		emit     = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr.ended) begin
					if (hdr.hdr_short) begin
						phase_d = PH_DONE;
					end else if (hdr.chunked) begin
						phase_d = PH_SIZE;
					end else begin
						phase_d = PH_PLAIN;
					end
				end
			end
			PH_PLAIN: begin
				emit = 1'b1;
			end
			PH_SIZE: begin
				if (sz.line_end) begin
					if (sz.stop) begin
						phase_d = PH_DONE;
					end else begin
						remain_d = sz.size;
						phase_d  = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (remain_q != '0) begin
					emit     = 1'b1;
					remain_d = remain_q - SIZE_BITS'(1);
				end
				if (remain_d == '0) begin
					phase_d = PH_SKIP;
					skip_d  = SKIP_LEN;
				end
			end
			PH_SKIP: begin
				if (skip_q != 2'd0) begin
					skip_d = skip_q - 2'd1;
				end
				if (skip_d == 2'd0) begin
					phase_d = PH_SIZE;
				end
			end
			default: begin
				// done: drop until the final byte
			end
		endcase
	end

	assign has_res = emit || last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			remain_q <= '0;
			skip_q   <= 2'd0;
		end else if (adv_s1) begin
			if (last) begin
				phase_q  <= PH_HEADER;
				remain_q <= '0;
				skip_q   <= 2'd0;
			end else begin
				phase_q  <= phase_d;
				remain_q <= remain_d;
				skip_q   <= skip_d;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_fire) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire) begin
			item_s1 <= byte_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1 && has_res) begin
			vld_s2 <= 1'b1;
		end else if (!body_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_res) begin
			res_s2.out_byte  <= emit ? item_s1.in_byte : 8'd0;
			res_s2.out_valid <= emit;
			res_s2.out_end   <= last;
		end
	end

	assign body_valid = vld_s2;
	assign body_data  = res_s2;

	// Checks

	a_res_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		body_valid |-> (body_data.out_valid || body_data.out_end))
		else $error("result transaction with neither body byte nor end mark");

	a_last_returns_header: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last) |=> (phase_q == PH_HEADER))
		else $error("final byte did not return decoder to header search");

	a_data_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (remain_q != '0))
		else $error("chunk data phase with zero bytes remaining");

	a_skip_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != 2'd0))
		else $error("skip phase with zero bytes to skip");

endmodule

### verif/testbench.sv
// Self-checking testbench for http_body_chunked_decoder_unit.
// Depends on hbcd_pkg and the decoder RTL; drives raw responses, checks decoded bytes.
`timescale 1ns / 1ps

module testbench;
	import hbcd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SHOWN   = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_data = '0;
	logic      body_valid;
	logic      body_stall = 1'b0;
	out_item_t body_data;

	http_body_chunked_decoder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.body_valid(body_valid),
		.body_stall(body_stall),
		.body_data (body_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle percentages for either side; changed between traffic phases
	int send_idle_pct = 34;
	int recv_idle_pct = 64;
	int err_cnt = 0;
	int taken_cnt = 0;
	int cycle_cnt = 0;

	// Expected output transactions, oldest first
	out_item_t pending_body[$];
	// Response under construction
	logic [7:0] resp_buf[$];

	// Decoder state as predicted
	phase_t               dec_phase;
	logic [31:0]          hdr_bytes;
	logic [2:0]           crlf_cnt;
	logic [4:0]           phrase_pos;
	logic                 chunked_seen;
	logic [SIZE_BITS-1:0] size_acc;
	logic                 digits_done;
	logic                 line_has_text;
	logic                 last_cr;
	logic [SIZE_BITS-1:0] data_left;
	logic [1:0]           skip_left;

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic void clear_size_line();
		size_acc      = '0;
		digits_done   = 1'b0;
		line_has_text = 1'b0;
		last_cr       = 1'b0;
	endfunction

	function automatic void reset_decoder();
		dec_phase    = PH_HEADER;
		hdr_bytes    = '0;
		crlf_cnt     = '0;
		phrase_pos   = '0;
		chunked_seen = 1'b0;
		clear_size_line();
		data_left    = '0;
		skip_left    = '0;
	endfunction

	// Predict the effect of one accepted byte; queue the result it causes, if any
	function automatic void decode_byte(input logic [7:0] c, input logic last);
		logic                 emit;
		logic                 hit_end;
		logic [7:0]           want_char;
		logic [SIZE_BITS+3:0] wide;
		int                   d;
		out_item_t            res;
		emit    = 1'b0;
		hit_end = 1'b0;
		case (dec_phase)
			PH_HEADER: begin
				case (crlf_cnt)
					3'd0: crlf_cnt = (c == CHAR_CR) ? 3'd1 : 3'd0;
					3'd1: crlf_cnt = (c == CHAR_LF) ? 3'd2 :
						(c == CHAR_CR) ? 3'd1 : 3'd0;
					3'd2: crlf_cnt = (c == CHAR_CR) ? 3'd3 : 3'd0;
					default: begin
						hit_end  = (c == CHAR_LF);
						crlf_cnt = (c == CHAR_CR) ? 3'd1 : 3'd0;
					end
				endcase
				if (!chunked_seen) begin
					want_char = PHRASE[PHRASE_BITS-1-8*int'(phrase_pos) -: 8];
					if (c == want_char)
						phrase_pos = phrase_pos + 5'd1;
					else
						phrase_pos = (c == PHRASE[PHRASE_BITS-1 -: 8]) ? 5'd1 : 5'd0;
					if (int'(phrase_pos) >= PHRASE_LEN) begin
						chunked_seen = 1'b1;
						phrase_pos   = '0;
					end
				end
				if (hit_end) begin
					crlf_cnt = '0;
					if (hdr_bytes < 32'(TAIL_MIN)) begin
						dec_phase = PH_DONE;
					end else if (chunked_seen) begin
						dec_phase = PH_SIZE;
						clear_size_line();
					end else begin
						dec_phase = PH_PLAIN;
					end
				end
				if (hdr_bytes != '1) hdr_bytes = hdr_bytes + 32'd1;
			end
			PH_PLAIN: emit = 1'b1;
			PH_SIZE: begin
				if (last_cr && c == CHAR_LF) begin
					if (!line_has_text || size_acc == '0) begin
						dec_phase = PH_DONE;
					end else begin
						data_left = size_acc;
						dec_phase = PH_DATA;
					end
					clear_size_line();
				end else begin
					// a lone CR is line content; CR LF alone is an empty line
					if (last_cr || c != CHAR_CR) line_has_text = 1'b1;
					last_cr = (c == CHAR_CR);
					if (!digits_done) begin
						d = hex_digit(c);
						if (d < 0) begin
							digits_done = 1'b1;
						end else begin
							wide     = {4'd0, size_acc} << 4 | (SIZE_BITS+4)'(d);
							size_acc = (wide[SIZE_BITS+3:SIZE_BITS] != 4'd0) ? '1
								: wide[SIZE_BITS-1:0];
						end
					end
				end
			end
			PH_DATA: begin
				if (data_left != '0) begin
					emit      = 1'b1;
					data_left = data_left - SIZE_BITS'(1);
				end
				if (data_left == '0) begin
					dec_phase = PH_SKIP;
					skip_left = SKIP_LEN;
				end
			end
			PH_SKIP: begin
				if (skip_left != '0) skip_left = skip_left - 2'd1;
				if (skip_left == '0) begin
					dec_phase = PH_SIZE;
					clear_size_line();
				end
			end
			default: ;
		endcase
		if (emit || last) begin
			res.out_byte  = emit ? c : 8'd0;
			res.out_valid = emit;
			res.out_end   = last;
			pending_body.push_back(res);
		end
		if (last) reset_decoder();
	endfunction

	// Output side: random stall per cycle
	always @(posedge clk) begin
		body_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && body_valid && !body_stall) begin
			if (pending_body.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN)
					$display("unexpected transaction: byte %02h valid %0b end %0b",
						body_data.out_byte, body_data.out_valid, body_data.out_end);
			end else begin
				want = pending_body.pop_front();
				if (body_data.out_byte !== want.out_byte ||
					body_data.out_valid !== want.out_valid ||
					body_data.out_end !== want.out_end) begin
					err_cnt++;
					if (err_cnt <= MAX_SHOWN)
						$display({"mismatch: exp byte %02h valid %0b end %0b, ",
							"got byte %02h valid %0b end %0b"},
							want.out_byte, want.out_valid, want.out_end,
							body_data.out_byte, body_data.out_valid, body_data.out_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Offer one byte; returns once the transaction has been taken
	task automatic push_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= '{in_byte: b, in_last: last};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		decode_byte(b, last);
		taken_cnt++;
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) resp_buf.push_back(s[i]);
	endtask

	task automatic add_line(input string s);
		add_str(s);
		resp_buf.push_back(CHAR_CR);
		resp_buf.push_back(CHAR_LF);
	endtask

	// Send the buffered response, in_last on its final byte
	task automatic flush_resp();
		if (resp_buf.size() == 0) resp_buf.push_back(8'($urandom));
		for (int i = 0; i < resp_buf.size(); i++)
			push_byte(resp_buf[i], i == resp_buf.size() - 1);
		resp_buf.delete();
	endtask

	// Sender holds off until every expected transaction has come out
	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (pending_body.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_rand_text(input int unsigned len);
		repeat (len) resp_buf.push_back(8'($urandom_range(32, 126)));
	endtask

	task automatic add_size_line(input int unsigned v);
		logic [7:0]  digs[$];
		int unsigned r;
		int unsigned d;
		r = v;
		do begin
			d = r % 16;
			if (d < 10)
				digs.push_front(8'(8'h30 + d));
			else
				digs.push_front(8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 10));
			r = r / 16;
		end while (r != 0);
		if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) digs.push_front(8'h30);
		foreach (digs[i]) resp_buf.push_back(digs[i]);
		if ($urandom_range(0, 99) < 20) begin
			add_str(";");
			add_rand_text($urandom_range(0, 6));
		end
		if ($urandom_range(0, 99) < 5) begin
			resp_buf.push_back(CHAR_CR);
			add_str("x");
		end
		add_line("");
	endtask

	task automatic add_chunk_header();
		add_line("Transfer-Encoding: chunked");
		add_line("");
	endtask

	task automatic test_plain_body();
		add_line("GET");
		add_line("");
		resp_buf.push_back(8'h00);
		resp_buf.push_back(8'hFF);
		add_str("ok");
		flush_resp();
	endtask

	task automatic test_chunked_body();
		add_chunk_header();
		add_line("3;x");
		add_str("abc");
		add_line("");
		add_line("A");
		for (int i = 0; i < 10; i++) resp_buf.push_back(i[0] ? 8'hFF : 8'h00);
		add_str("zz");
		add_line("0");
		add_line("");
		add_str("t");
		flush_resp();
	endtask

	task automatic test_header_edges();
		// terminator at the very first byte: nothing is body
		add_line("");
		add_line("");
		add_str("ab");
		flush_resp();
		// no terminator at all
		add_str("abc");
		flush_resp();
		// shortest header that still counts
		add_line("x");
		add_line("");
		add_str("y");
		flush_resp();
		add_str("Z");
		flush_resp();
	endtask

	task automatic test_size_lines();
		// saturating size, response ends inside the data
		add_chunk_header();
		add_line("fFfFfFfFf0");
		add_str("sat");
		flush_resp();
		// lone CR inside the size line, then an empty line ends decoding
		add_chunk_header();
		add_str("2");
		resp_buf.push_back(CHAR_CR);
		add_str("q");
		add_line("");
		add_str("hi--");
		add_line("");
		add_str("junk");
		flush_resp();
		// non-hex first character gives size zero
		add_chunk_header();
		add_line("g5");
		add_str("xx");
		flush_resp();
	endtask

	task automatic gen_response();
		int unsigned len;
		int unsigned nlines;
		int unsigned phrase_at;
		int unsigned nchunks;
		int unsigned pick;
		bit          chunked;
		bit          sat;
		if ($urandom_range(0, 99) < 10) begin
			// pure noise
			repeat ($urandom_range(1, 40)) resp_buf.push_back(8'($urandom));
		end else begin
			chunked = ($urandom_range(0, 99) < 65);
			sat     = 1'b0;
			if ($urandom_range(0, 99) < 4) begin
				add_line("");
			end else begin
				add_line("HTTP/1.1 200 OK");
				nlines    = $urandom_range(0, 3);
				phrase_at = $urandom_range(0, nlines);
				for (int i = 0; i <= nlines; i++) begin
					if (chunked && i == phrase_at) begin
						pick = $urandom_range(0, 99);
						if (pick < 70)      add_line("Transfer-Encoding: chunked");
						else if (pick < 85) add_line("TTransfer-Encoding: chunked");
						else                add_line("Transfer-Encoding: chunkeD");
					end else if (i < nlines) begin
						add_rand_text(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12));
						add_line("");
					end
				end
			end
			add_line("");
			if (chunked) begin
				nchunks = $urandom_range(0, 3);
				for (int k = 0; k < nchunks && !sat; k++) begin
					if ($urandom_range(0, 24) == 0) begin
						// huge size: the response is cut short inside the data
						repeat ($urandom_range(9, 12)) add_str($urandom_range(0, 1) ? "f" : "F");
						add_line("");
						repeat ($urandom_range(1, 6)) resp_buf.push_back(8'($urandom));
						sat = 1'b1;
					end else begin
						len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
							: $urandom_range(1, 12);
						add_size_line(len);
						repeat (len) resp_buf.push_back(8'($urandom));
						if ($urandom_range(0, 9) == 0) begin
							resp_buf.push_back(8'($urandom));
							resp_buf.push_back(8'($urandom));
						end else begin
							add_line("");
						end
					end
				end
				if (!sat) begin
					if ($urandom_range(0, 99) < 20) add_line("");
					else add_size_line(0);
					add_line("");
					if ($urandom_range(0, 99) < 30) add_rand_text($urandom_range(1, 8));
				end
			end else begin
				repeat ($urandom_range(0, 24)) resp_buf.push_back(8'($urandom));
			end
			// broken sequence: cut the response anywhere
			if ($urandom_range(0, 99) < 15) begin
				len = $urandom_range(1, resp_buf.size());
				while (resp_buf.size() > len) void'(resp_buf.pop_back());
			end
		end
		flush_resp();
	endtask

	task automatic test_random_traffic();
		int target;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_idle_pct = 34; recv_idle_pct = 64; end
				1: begin send_idle_pct = 64; recv_idle_pct = 34; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			target = taken_cnt + 340;
			while (taken_cnt < target) gen_response();
			wait_drained();
		end
	endtask

	initial begin
		reset_decoder();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_body();
		test_chunked_body();
		test_header_edges();
		test_size_lines();
		wait_drained();
		test_random_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
